>>> hw/rtl/dlfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlfs_pkg;

    localparam int MAX_WORDS = 6;
    localparam int CNT_W     = 3;

    // input item kinds (kind 3 is unused)
    localparam logic [1:0] KIND_PROGRAM = 2'd0;
    localparam logic [1:0] KIND_ERASE   = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_PROG_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_ERASE_LIMIT = 3'd1;
    localparam logic [2:0] CFG_PROG_WAIT   = 3'd2;
    localparam logic [2:0] CFG_VERIFY_WAIT = 3'd3;
    localparam logic [2:0] CFG_ERASE_WAIT  = 3'd4;
    localparam logic [2:0] CFG_ERASE_SPAN  = 3'd5;

    // flash command words
    localparam logic [15:0] CMD_PROGRAM    = 16'h4040;
    localparam logic [15:0] CMD_VERIFY     = 16'hc0c0;
    localparam logic [15:0] CMD_PROG_HI    = 16'h40ff;
    localparam logic [15:0] CMD_VERIFY_HI  = 16'hc0ff;
    localparam logic [15:0] CMD_PROG_LO    = 16'hff40;
    localparam logic [15:0] CMD_VERIFY_LO  = 16'hffc0;
    localparam logic [15:0] CMD_ERASE      = 16'h2020;
    localparam logic [15:0] CMD_ERASE_VFY  = 16'ha0a0;
    localparam logic [15:0] LANE_BOTH      = 16'hffff;
    localparam logic [15:0] LANE_HI        = 16'hff00;
    localparam logic [15:0] LANE_LO        = 16'h00ff;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_WAIT  = 2'd2,
        OP_DONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PROG_FAIL  = 2'd1,
        ST_ERASE_FAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_PROGRAM = 3'b010,
        MODE_ERASE   = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0]  prog_limit;
        logic [15:0] erase_limit;
        logic [9:0]  prog_wait;
        logic [9:0]  verify_wait;
        logic [15:0] erase_wait;
        logic [20:0] erase_span;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] target_value;
        logic [15:0] program_command;
        logic [15:0] verify_command;
        logic [15:0] attempt_count;
        logic [15:0] erase_mask;
    } t_seq;

endpackage

`default_nettype wire

>>> hw/rtl/dlfs_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module dlfs_decode #(
    parameter int ADDRESS_BITS = 20,
    localparam int RW = 2 + ADDRESS_BITS + 16 + 16 + 2
) (
    input  wire logic [1:0]                 i_kind,
    input  wire logic [ADDRESS_BITS-1:0]    i_address,
    input  wire logic [15:0]                i_value,
    input  wire logic [15:0]                i_lane_mask,
    input  wire logic [15:0]                i_read_data,
    input  wire dlfs_pkg::t_cfg             i_cfg,
    input  wire dlfs_pkg::t_seq             i_seq,
    input  wire logic [ADDRESS_BITS-1:0]    i_target,
    input  wire logic [ADDRESS_BITS-1:0]    i_scan,
    output dlfs_pkg::t_seq                  o_seq,
    output logic [ADDRESS_BITS-1:0]         o_target,
    output logic [ADDRESS_BITS-1:0]         o_scan,
    output logic [dlfs_pkg::CNT_W-1:0]      o_count,
    output logic [5:0][RW-1:0]              o_rec
);

    localparam int AB = ADDRESS_BITS;
    localparam int CW = (AB + 1 > 21) ? AB + 1 : 21;

    function automatic logic [RW-1:0] mk(dlfs_pkg::t_op op, logic [AB-1:0] a,
                                         logic [15:0] d, logic [15:0] w,
                                         dlfs_pkg::t_status st);
        return {op, a, d, w, st};
    endfunction

    logic [15:0]   att_inc;
    logic [15:0]   pc;
    logic [15:0]   vc;
    logic [15:0]   em;
    logic [15:0]   pwait;
    logic [15:0]   vwait;
    logic [AB-1:0] diff;
    logic [AB-1:0] scan_nx;
    logic [CW-1:0] span_c;
    logic [CW-1:0] lim_c;
    logic [CW-1:0] off_c;
    logic          idle;

    always_comb begin
        idle    = (i_seq.mode == dlfs_pkg::MODE_IDLE);
        att_inc = (i_seq.attempt_count != dlfs_pkg::COUNT_MAX)
                ? i_seq.attempt_count + 16'd1 : i_seq.attempt_count;
        pwait   = {6'd0, i_cfg.prog_wait};
        vwait   = {6'd0, i_cfg.verify_wait};

        // narrow the pulse to the lanes that still mismatch
        pc = dlfs_pkg::LANE_BOTH;
        vc = dlfs_pkg::LANE_BOTH;
        if (i_read_data[15:8] != i_seq.target_value[15:8]) begin
            pc = pc & dlfs_pkg::CMD_PROG_HI;
            vc = vc & dlfs_pkg::CMD_VERIFY_HI;
        end
        if (i_read_data[7:0] != i_seq.target_value[7:0]) begin
            pc = pc & dlfs_pkg::CMD_PROG_LO;
            vc = vc & dlfs_pkg::CMD_VERIFY_LO;
        end
        em = ((i_read_data[15:8] != 8'hff) ? dlfs_pkg::LANE_HI : 16'h0000)
           | ((i_read_data[7:0] != 8'hff) ? dlfs_pkg::LANE_LO : 16'h0000);

        // span saturates at the address space
        lim_c     = '0;
        lim_c[AB] = 1'b1;
        span_c    = CW'(i_cfg.erase_span);
        if (span_c > lim_c) begin
            span_c = lim_c;
        end
        diff    = i_scan - i_target;
        off_c   = CW'(diff) + CW'(2);
        scan_nx = i_scan + AB'(2);

        o_seq    = i_seq;
        o_target = i_target;
        o_scan   = i_scan;
        o_count  = '0;
        o_rec    = '0;

        if (i_kind == dlfs_pkg::KIND_PROGRAM && idle) begin
            o_target              = i_address;
            o_seq.target_value    = i_value;
            o_seq.program_command = dlfs_pkg::CMD_PROGRAM;
            o_seq.verify_command  = dlfs_pkg::CMD_VERIFY;
            o_seq.attempt_count   = '0;
            o_seq.mode            = dlfs_pkg::MODE_PROGRAM;
            o_count  = 3'd6;
            o_rec[0] = mk(dlfs_pkg::OP_WRITE, i_address, dlfs_pkg::CMD_PROGRAM, '0,
                          dlfs_pkg::ST_OK);
            o_rec[1] = mk(dlfs_pkg::OP_WRITE, i_address, i_value, '0, dlfs_pkg::ST_OK);
            o_rec[2] = mk(dlfs_pkg::OP_WAIT, '0, '0, pwait, dlfs_pkg::ST_OK);
            o_rec[3] = mk(dlfs_pkg::OP_WRITE, i_address, dlfs_pkg::CMD_VERIFY, '0,
                          dlfs_pkg::ST_OK);
            o_rec[4] = mk(dlfs_pkg::OP_WAIT, '0, '0, vwait, dlfs_pkg::ST_OK);
            o_rec[5] = mk(dlfs_pkg::OP_READ, i_address, '0, '0, dlfs_pkg::ST_OK);
        end else if (i_kind == dlfs_pkg::KIND_ERASE && idle) begin
            o_target            = i_address;
            o_scan              = i_address;
            o_seq.erase_mask    = i_lane_mask;
            o_seq.attempt_count = '0;
            o_seq.mode          = dlfs_pkg::MODE_ERASE;
            o_count  = 3'd5;
            o_rec[0] = mk(dlfs_pkg::OP_WRITE, i_address, dlfs_pkg::CMD_ERASE & i_lane_mask,
                          '0, dlfs_pkg::ST_OK);
            o_rec[1] = o_rec[0];
            o_rec[2] = mk(dlfs_pkg::OP_WAIT, '0, '0, i_cfg.erase_wait, dlfs_pkg::ST_OK);
            o_rec[3] = mk(dlfs_pkg::OP_WRITE, i_address,
                          dlfs_pkg::CMD_ERASE_VFY & i_lane_mask, '0, dlfs_pkg::ST_OK);
            o_rec[4] = mk(dlfs_pkg::OP_READ, i_address, '0, '0, dlfs_pkg::ST_OK);
        end else if (i_kind == dlfs_pkg::KIND_READ
                     && i_seq.mode == dlfs_pkg::MODE_PROGRAM) begin
            o_seq.attempt_count = att_inc;
            o_count = 3'd1;
            if (i_read_data == i_seq.target_value) begin
                o_seq.mode = dlfs_pkg::MODE_IDLE;
                o_rec[0]   = mk(dlfs_pkg::OP_DONE, '0, '0, '0, dlfs_pkg::ST_OK);
            end else if (att_inc >= {8'd0, i_cfg.prog_limit}) begin
                o_seq.mode = dlfs_pkg::MODE_IDLE;
                o_rec[0]   = mk(dlfs_pkg::OP_DONE, '0, '0, '0, dlfs_pkg::ST_PROG_FAIL);
            end else begin
                o_seq.program_command = pc;
                o_seq.verify_command  = vc;
                o_count  = 3'd6;
                o_rec[0] = mk(dlfs_pkg::OP_WRITE, i_target, pc, '0, dlfs_pkg::ST_OK);
                o_rec[1] = mk(dlfs_pkg::OP_WRITE, i_target, i_seq.target_value, '0,
                              dlfs_pkg::ST_OK);
                o_rec[2] = mk(dlfs_pkg::OP_WAIT, '0, '0, pwait, dlfs_pkg::ST_OK);
                o_rec[3] = mk(dlfs_pkg::OP_WRITE, i_target, vc, '0, dlfs_pkg::ST_OK);
                o_rec[4] = mk(dlfs_pkg::OP_WAIT, '0, '0, vwait, dlfs_pkg::ST_OK);
                o_rec[5] = mk(dlfs_pkg::OP_READ, i_target, '0, '0, dlfs_pkg::ST_OK);
            end
        end else if (i_kind == dlfs_pkg::KIND_READ
                     && i_seq.mode == dlfs_pkg::MODE_ERASE) begin
            if (i_read_data != dlfs_pkg::LANE_BOTH) begin
                o_seq.attempt_count = att_inc;
                if (i_seq.attempt_count > i_cfg.erase_limit
                    && att_inc > i_seq.attempt_count) begin
                    o_seq.mode = dlfs_pkg::MODE_IDLE;
                    o_count    = 3'd1;
                    o_rec[0]   = mk(dlfs_pkg::OP_DONE, '0, '0, '0,
                                    dlfs_pkg::ST_ERASE_FAIL);
                end else begin
                    // restart the erase on the failing lanes
                    o_seq.erase_mask = em;
                    o_scan   = i_target;
                    o_count  = 3'd5;
                    o_rec[0] = mk(dlfs_pkg::OP_WRITE, i_target, dlfs_pkg::CMD_ERASE & em,
                                  '0, dlfs_pkg::ST_OK);
                    o_rec[1] = o_rec[0];
                    o_rec[2] = mk(dlfs_pkg::OP_WAIT, '0, '0, i_cfg.erase_wait,
                                  dlfs_pkg::ST_OK);
                    o_rec[3] = mk(dlfs_pkg::OP_WRITE, i_target,
                                  dlfs_pkg::CMD_ERASE_VFY & em, '0, dlfs_pkg::ST_OK);
                    o_rec[4] = mk(dlfs_pkg::OP_READ, i_target, '0, '0, dlfs_pkg::ST_OK);
                end
            end else if (off_c >= span_c) begin
                o_seq.mode = dlfs_pkg::MODE_IDLE;
                o_count    = 3'd1;
                o_rec[0]   = mk(dlfs_pkg::OP_DONE, '0, '0, '0, dlfs_pkg::ST_OK);
            end else begin
                // advance to the next halfword of the span
                o_scan   = scan_nx;
                o_count  = 3'd2;
                o_rec[0] = mk(dlfs_pkg::OP_WRITE, scan_nx,
                              dlfs_pkg::CMD_ERASE_VFY & i_seq.erase_mask, '0,
                              dlfs_pkg::ST_OK);
                o_rec[1] = mk(dlfs_pkg::OP_READ, scan_nx, '0, '0, dlfs_pkg::ST_OK);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dlfs_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module dlfs_emit #(
    parameter int ADDRESS_BITS = 20,
    localparam int RW = 2 + ADDRESS_BITS + 16 + 16 + 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [dlfs_pkg::CNT_W-1:0]  i_count,
    input  wire logic [5:0][RW-1:0]          i_rec,
    input  wire logic                        i_ready,
    output logic                             o_free,
    output logic                             o_valid,
    output logic [1:0]                       o_op,
    output logic [ADDRESS_BITS-1:0]          o_bus_address,
    output logic [15:0]                      o_bus_data,
    output logic [15:0]                      o_wait_us,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    localparam int AB = ADDRESS_BITS;

    logic [5:0][RW-1:0]          r_rec;
    logic [dlfs_pkg::CNT_W-1:0]  r_cnt;
    logic                        take;

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && i_ready;
    assign o_free  = (r_cnt == '0) || (r_cnt == 3'd1 && i_ready);
    assign o_last  = (r_cnt == 3'd1);

    assign o_op          = r_rec[0][RW-1 -: 2];
    assign o_bus_address = r_rec[0][RW-3 -: AB];
    assign o_bus_data    = r_rec[0][33:18];
    assign o_wait_us     = r_rec[0][17:2];
    assign o_status      = r_rec[0][1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // shift the next word to the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end else if (take) begin
            for (int i = 0; i < 5; i++) begin
                r_rec[i] <= r_rec[i+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(dlfs_pkg::MAX_WORDS))
        else $error("word count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("load while words pending");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/dual_lane_flash_program_erase_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted word is registered, then decoded into its bus words once the output buffer
// is free; the bus words are registered in that buffer before they are valid. Each input
// yields N (0 to 6) result words; the buffer issues one word per cycle while i_ready is high
// and loads the next input as its last word goes; inputs with none pass at one per cycle while it is empty.
// Reset: synchronous active low; config returns to defaults, sequencer idle, buffers empty.

module dual_lane_flash_program_erase_sequencer #(
    parameter int ADDRESS_BITS = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_index,
    input  wire logic [20:0]              i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_kind,
    input  wire logic [ADDRESS_BITS-1:0]  i_address,
    input  wire logic [15:0]              i_value,
    input  wire logic [15:0]              i_lane_mask,
    input  wire logic [15:0]              i_read_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_op,
    output logic [ADDRESS_BITS-1:0]       o_bus_address,
    output logic [15:0]                   o_bus_data,
    output logic [15:0]                   o_wait_us,
    output logic [1:0]                    o_status,
    output logic                          o_last
);

    localparam int AB = ADDRESS_BITS;
    localparam int RW = 2 + AB + 16 + 16 + 2;

    dlfs_pkg::t_cfg              r_cfg;
    dlfs_pkg::t_seq              r_seq;
    dlfs_pkg::t_seq              n_seq;
    logic [AB-1:0]               r_target;
    logic [AB-1:0]               n_target;
    logic [AB-1:0]               r_scan;
    logic [AB-1:0]               n_scan;

    logic                        r_in_valid;
    logic [1:0]                  r_kind;
    logic [AB-1:0]               r_address;
    logic [15:0]                 r_value;
    logic [15:0]                 r_lane_mask;
    logic [15:0]                 r_read_data;

    logic [dlfs_pkg::CNT_W-1:0]  dec_count;
    logic [5:0][RW-1:0]          dec_rec;
    logic                        emit_free;
    logic                        consume;

    assign consume = r_in_valid && emit_free;
    assign o_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prog_limit  <= 8'd50;
            r_cfg.erase_limit <= 16'd3000;
            r_cfg.prog_wait   <= 10'd10;
            r_cfg.verify_wait <= 10'd6;
            r_cfg.erase_wait  <= 16'd10000;
            r_cfg.erase_span  <= 21'd524288;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dlfs_pkg::CFG_PROG_LIMIT:  r_cfg.prog_limit  <= i_cfg_data[7:0];
                dlfs_pkg::CFG_ERASE_LIMIT: r_cfg.erase_limit <= i_cfg_data[15:0];
                dlfs_pkg::CFG_PROG_WAIT:   r_cfg.prog_wait   <= i_cfg_data[9:0];
                dlfs_pkg::CFG_VERIFY_WAIT: r_cfg.verify_wait <= i_cfg_data[9:0];
                dlfs_pkg::CFG_ERASE_WAIT:  r_cfg.erase_wait  <= i_cfg_data[15:0];
                dlfs_pkg::CFG_ERASE_SPAN:  r_cfg.erase_span  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // hold the input word until the decoder takes it
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind      <= i_kind;
            r_address   <= i_address;
            r_value     <= i_value;
            r_lane_mask <= i_lane_mask;
            r_read_data <= i_read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.mode            <= dlfs_pkg::MODE_IDLE;
            r_seq.target_value    <= '0;
            r_seq.program_command <= dlfs_pkg::CMD_PROGRAM;
            r_seq.verify_command  <= dlfs_pkg::CMD_VERIFY;
            r_seq.attempt_count   <= '0;
            r_seq.erase_mask      <= dlfs_pkg::LANE_BOTH;
            r_target              <= '0;
            r_scan                <= '0;
        end else if (consume) begin
            r_seq    <= n_seq;
            r_target <= n_target;
            r_scan   <= n_scan;
        end
    end

    dlfs_decode #(.ADDRESS_BITS(ADDRESS_BITS)) u_decode (
        .i_kind      (r_kind),
        .i_address   (r_address),
        .i_value     (r_value),
        .i_lane_mask (r_lane_mask),
        .i_read_data (r_read_data),
        .i_cfg       (r_cfg),
        .i_seq       (r_seq),
        .i_target    (r_target),
        .i_scan      (r_scan),
        .o_seq       (n_seq),
        .o_target    (n_target),
        .o_scan      (n_scan),
        .o_count     (dec_count),
        .o_rec       (dec_rec)
    );

    dlfs_emit #(.ADDRESS_BITS(ADDRESS_BITS)) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (consume),
        .i_count       (dec_count),
        .i_rec         (dec_rec),
        .i_ready       (i_ready),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .o_op          (o_op),
        .o_bus_address (o_bus_address),
        .o_bus_data    (o_bus_data),
        .o_wait_us     (o_wait_us),
        .o_status      (o_status),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_op == dlfs_pkg::OP_DONE) |-> o_last)
        else $error("done word not marked last");

    a_idle_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_kind == dlfs_pkg::KIND_READ && r_seq.mode == dlfs_pkg::MODE_IDLE)
        |-> (dec_count == '0))
        else $error("read return while idle produced words");

    a_busy_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_kind == dlfs_pkg::KIND_PROGRAM
         && r_seq.mode != dlfs_pkg::MODE_IDLE) |=> $stable(r_target))
        else $error("request while busy changed the target");
`endif

endmodule

`default_nettype wire
